[hw/rtl/ntt_pkg.sv]
// Shared types, constants and elaboration-time math for the NTT convolution block.
package ntt_pkg;

	localparam int LOG_SIZE_DEF = 10;
	localparam int LEN_W = 11;
	localparam int IDX_W = 10;
	localparam int VAL_W = 30;
	localparam int MODE_W = 2;
	localparam int STS_W = 2;

	localparam logic [29:0] PRIME = 30'd998244353;
	// -PRIME^-1 mod 2^32
	localparam logic [31:0] P_NINV = 32'd998244351;
	// 2^32 mod PRIME, also the Montgomery form of one
	localparam logic [29:0] R_MOD = 30'd301989884;
	// primitive root of order 2^23 and its inverse
	localparam logic [29:0] ROOT_MAX = 30'd15311432;
	localparam logic [29:0] IROOT_MAX = 30'd469870224;
	localparam int ROOT_LOG = 23;
	localparam int MUL_LAT = 4;

	typedef enum logic [1:0] {
		MODE_WR_A,
		MODE_WR_B,
		MODE_CONV,
		MODE_READ
	} mode_t;

	typedef enum logic [1:0] {
		STS_OK,
		STS_TOO_LONG,
		STS_RANGE
	} sts_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOAD_RD,
		ST_LOAD_WA,
		ST_LOAD_WB,
		ST_BF_RD,
		ST_BF_MUL,
		ST_BF_WAIT,
		ST_BF_WR0,
		ST_BF_WR1,
		ST_EL_RD,
		ST_EL_MUL,
		ST_EL_WAIT,
		ST_EL_WR,
		ST_FINISH
	} state_t;

	typedef enum logic [2:0] {
		PH_FWD_A,
		PH_FWD_B,
		PH_POINT,
		PH_INV,
		PH_SCALE
	} phase_t;

	function automatic logic [29:0] mulmod_c(logic [29:0] a, logic [29:0] b);
		logic [59:0] t;
		t = 60'(a) * 60'(b);
		return 30'(t % 60'(PRIME));
	endfunction

	// root of unity of order 2^lg
	function automatic logic [29:0] pow2root(int lg, logic inv);
		logic [29:0] r;
		r = inv ? IROOT_MAX : ROOT_MAX;
		for (int s = ROOT_LOG; s > lg; s--) begin
			r = mulmod_c(r, r);
		end
		return r;
	endfunction

	function automatic logic [29:0] tw_mont(int lg, logic inv);
		return mulmod_c(pow2root(lg, inv), R_MOD);
	endfunction

	// n^-1 * R^2: turns a product of two Montgomery reductions into x / n
	function automatic logic [29:0] scale_mont(int ln);
		logic [29:0] ninv;
		ninv = PRIME - 30'((PRIME - 30'd1) >> ln);
		return mulmod_c(mulmod_c(ninv, R_MOD), R_MOD);
	endfunction

endpackage

[hw/rtl/ntt_mont_mul.sv]
// Four-stage pipelined Montgomery multiplier modulo PRIME, R = 2^32.
module ntt_mont_mul (
	input  logic        clk,
	input  logic [29:0] x,
	input  logic [29:0] y,
	output logic [29:0] z
);
	import ntt_pkg::*;

	logic [59:0] t_s1, t_s2, t_s3;
	logic [31:0] m_s2;
	logic [61:0] mp_s3;
	logic [62:0] sum;
	logic [30:0] u;
	logic [29:0] z_s4;

	assign sum = 63'(t_s3) + 63'(mp_s3);
	assign u   = sum[62:32];

	always_ff @(posedge clk) begin
		t_s1  <= 60'(x) * 60'(y);
		m_s2  <= 32'(t_s1[31:0] * P_NINV);
		t_s2  <= t_s1;
		mp_s3 <= 62'(m_s2) * 62'(PRIME);
		t_s3  <= t_s2;
		z_s4  <= (u >= 31'(PRIME)) ? 30'(u - 31'(PRIME)) : u[29:0];
	end

	assign z = z_s4;

endmodule

[hw/rtl/ntt_convolution_top.sv]
// Top level of the NTT convolution block: item sequencer, work and scratch memories.
//
//   channel   | ports                                        | transfer when
//   ----------+----------------------------------------------+------------------------
//   item in   | start, busy, mode, index, coefficient_value  | start high, busy low
//   result    | done, product_value, status                  | every cycle done is high
//   config    | cfg_we, cfg_addr, cfg_wdata                  | every cycle cfg_we is high
//
// Writes, reads and a convolve that is too long leave busy low; the result shows in
// the cycle after the transfer, so they stream back to back.
// A convolve of transform size n holds busy through a load of n entries, then
// 3 * (n/2) * log2(n) butterflies and up to 2n elementwise steps, done one at a
// time by the one butterfly unit and the single scratch write port.
// The result never stalls: done is high for exactly one cycle.
// Reset clears control and lengths only; memories need no clearing pass.
module ntt_convolution_top #(
	parameter int LOG_SIZE = ntt_pkg::LOG_SIZE_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [ntt_pkg::MODE_W-1:0] mode,
	input  logic [ntt_pkg::IDX_W-1:0]  index,
	input  logic [ntt_pkg::VAL_W-1:0]  coefficient_value,
	output logic                       done,
	output logic [ntt_pkg::VAL_W-1:0]  product_value,
	output logic [ntt_pkg::STS_W-1:0]  status,
	input  logic                       cfg_we,
	input  logic                       cfg_addr,
	input  logic [ntt_pkg::LEN_W-1:0]  cfg_wdata
);
	import ntt_pkg::*;

	localparam int SIZE = 1 << LOG_SIZE;
	localparam int AW   = LOG_SIZE;
	localparam int SAW  = LOG_SIZE + 1;
	localparam int HW   = $clog2(LOG_SIZE + 1);
	localparam int CW   = (LOG_SIZE + 1 > 12) ? LOG_SIZE + 1 : 12;
	localparam int WTW  = $clog2(MUL_LAT);

	// memories: raw a and b coefficients, product over a; scratch holds both transforms
	logic [29:0] wa_mem [SIZE];
	logic [29:0] wb_mem [SIZE];
	logic [29:0] scr_mem [2 * SIZE];

	logic [29:0] fwd_tw [LOG_SIZE + 1];
	logic [29:0] inv_tw [LOG_SIZE + 1];
	logic [29:0] scl_k  [LOG_SIZE + 1];

	for (genvar g = 0; g <= LOG_SIZE; g++) begin : g_tab
		assign fwd_tw[g] = tw_mont(g, 1'b0);
		assign inv_tw[g] = tw_mont(g, 1'b1);
		assign scl_k[g]  = scale_mont(g);
	end

	state_t            state_q, state_d;
	phase_t            phase_q;
	logic [LEN_W-1:0]  length_a_q, length_b_q, plen_q;
	logic [CW-1:0]     c_q;
	logic [HW-1:0]     ln_q, lg_q;
	logic [AW-1:0]     j_q, end_q;
	logic [WTW-1:0]    wait_q;
	logic [29:0]       wn_q, u_q, v_q, p_q;
	logic              done_q, rsel_q;
	logic [STS_W-1:0]  status_q;

	logic [29:0]       wa_rd_q, wb_rd_q, sr0_q, sr1_q;

	logic              acc;
	mode_t             mode_in;
	logic [CW-1:0]     sum_ab, c_comb;
	logic              too_long;
	logic [HW-1:0]     ln_comb;
	logic              idx_ok, rd_ok;

	logic [AW-1:0]     lmask, half, a0, a1, nm1_ln, nm1_new;
	logic              bank, inv_pass, last_stage, j_end;
	logic [29:0]       wn_eff, tw_cur;

	logic              wa_re, wb_re, wa_we, wb_we, scr_re, scr_we;
	logic [AW-1:0]     wa_raddr, wa_waddr, wb_waddr;
	logic [29:0]       wa_wdata, wb_wdata, scr_wdata;
	logic [SAW-1:0]    scr_raddr0, scr_raddr1, scr_waddr;

	logic [29:0]       mx, my, wx, wy, mz, wz;
	logic [29:0]       a_load, b_load, bf_x0, bf_x1, bf_diff;

	function automatic logic [29:0] add_p(logic [29:0] a, logic [29:0] b);
		logic [30:0] s;
		s = 31'(a) + 31'(b);
		return (s >= 31'(PRIME)) ? 30'(s - 31'(PRIME)) : s[29:0];
	endfunction

	function automatic logic [29:0] sub_p(logic [29:0] a, logic [29:0] b);
		return (a >= b) ? 30'(a - b) : 30'(31'(a) + 31'(PRIME) - 31'(b));
	endfunction

	function automatic logic [29:0] red_p(logic [29:0] a);
		return (a >= PRIME) ? 30'(a - PRIME) : a;
	endfunction

	ntt_mont_mul u_mul_data (.clk(clk), .x(mx), .y(my), .z(mz));
	ntt_mont_mul u_mul_tw   (.clk(clk), .x(wx), .y(wy), .z(wz));

	// item decode
	assign mode_in  = mode_t'(mode);
	assign acc      = start && (state_q == ST_IDLE);
	assign busy     = (state_q != ST_IDLE);
	assign sum_ab   = CW'(length_a_q) + CW'(length_b_q);
	assign c_comb   = (sum_ab == '0) ? '0 : sum_ab - CW'(1);
	assign too_long = c_comb > CW'(SIZE);
	assign idx_ok   = CW'(index) < CW'(SIZE);
	assign rd_ok    = CW'(index) < CW'(plen_q);

	// smallest transform log size that holds the product
	always_comb begin
		ln_comb = '0;
		for (int k = LOG_SIZE; k >= 0; k--) begin
			if ((CW'(1) << k) >= c_comb) ln_comb = HW'(k);
		end
	end

	assign nm1_ln  = AW'((SAW'(1) << ln_q) - SAW'(1));
	assign nm1_new = AW'((SAW'(1) << ln_comb) - SAW'(1));

	// butterfly addressing: insert a zero bit at the half-span position
	assign lmask  = AW'((SAW'(1) << (lg_q - HW'(1))) - SAW'(1));
	assign half   = lmask + AW'(1);
	assign a0     = AW'((j_q & ~lmask) << 1) | (j_q & lmask);
	assign a1     = a0 | half;
	assign bank   = (phase_q == PH_FWD_B);
	assign inv_pass   = (phase_q == PH_INV);
	assign last_stage = inv_pass ? (lg_q == ln_q) : (lg_q == HW'(1));
	assign j_end  = (j_q == end_q);
	assign wn_eff = ((j_q & lmask) == '0) ? R_MOD : wn_q;
	assign tw_cur = inv_pass ? inv_tw[lg_q] : fwd_tw[lg_q];

	assign a_load  = (CW'(j_q) < CW'(length_a_q)) ? red_p(wa_rd_q) : '0;
	assign b_load  = (CW'(j_q) < CW'(length_b_q)) ? red_p(wb_rd_q) : '0;
	assign bf_diff = sub_p(sr0_q, sr1_q);
	// inverse pass: the product is on the multiplier output during the first write
	assign bf_x0   = inv_pass ? add_p(u_q, mz) : add_p(u_q, v_q);
	assign bf_x1   = inv_pass ? sub_p(u_q, p_q) : p_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (acc && mode_in == MODE_CONV && !too_long) state_d = ST_LOAD_RD;
			end
			ST_LOAD_RD: state_d = ST_LOAD_WA;
			ST_LOAD_WA: state_d = ST_LOAD_WB;
			ST_LOAD_WB: begin
				if (!j_end) state_d = ST_LOAD_RD;
				else if (ln_q == '0) state_d = ST_EL_RD;
				else state_d = ST_BF_RD;
			end
			ST_BF_RD:  state_d = ST_BF_MUL;
			ST_BF_MUL: state_d = ST_BF_WAIT;
			ST_BF_WAIT: begin
				if (wait_q == WTW'(MUL_LAT - 2)) state_d = ST_BF_WR0;
			end
			ST_BF_WR0: state_d = ST_BF_WR1;
			ST_BF_WR1: begin
				if (!j_end || !last_stage) state_d = ST_BF_RD;
				else if (phase_q == PH_FWD_A) state_d = ST_BF_RD;
				else if (phase_q == PH_FWD_B) state_d = ST_EL_RD;
				else if (c_q == '0) state_d = ST_FINISH;
				else state_d = ST_EL_RD;
			end
			ST_EL_RD:  state_d = ST_EL_MUL;
			ST_EL_MUL: state_d = ST_EL_WAIT;
			ST_EL_WAIT: begin
				if (wait_q == WTW'(MUL_LAT - 2)) state_d = ST_EL_WR;
			end
			ST_EL_WR: begin
				if (!j_end) state_d = ST_EL_RD;
				else if (phase_q == PH_SCALE) state_d = ST_FINISH;
				else if (ln_q != '0) state_d = ST_BF_RD;
				else if (c_q == '0) state_d = ST_FINISH;
				else state_d = ST_EL_RD;
			end
			ST_FINISH: state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// memory and multiplier controls
	always_comb begin
		wa_re = 1'b0;  wa_raddr = j_q;
		wb_re = 1'b0;
		wa_we = 1'b0;  wa_waddr = AW'(index);  wa_wdata = coefficient_value;
		wb_we = 1'b0;  wb_waddr = AW'(index);  wb_wdata = coefficient_value;
		scr_re = 1'b0; scr_raddr0 = {bank, a0}; scr_raddr1 = {bank, a1};
		scr_we = 1'b0; scr_waddr = {1'b0, j_q}; scr_wdata = a_load;
		mx = sr0_q; my = sr1_q; wx = wn_eff; wy = tw_cur;
		unique case (state_q)
			ST_IDLE: begin
				if (acc) begin
					unique case (mode_in)
						MODE_WR_A: wa_we = idx_ok;
						MODE_WR_B: wb_we = idx_ok;
						MODE_READ: begin
							wa_re    = 1'b1;
							wa_raddr = AW'(index);
						end
						MODE_CONV: ;
						default:   ;
					endcase
				end
			end
			ST_LOAD_RD: begin
				wa_re = 1'b1;
				wb_re = 1'b1;
			end
			ST_LOAD_WA: scr_we = 1'b1;
			ST_LOAD_WB: begin
				scr_we    = 1'b1;
				scr_waddr = {1'b1, j_q};
				scr_wdata = b_load;
			end
			ST_BF_RD: scr_re = 1'b1;
			ST_BF_MUL: begin
				mx = inv_pass ? sr1_q : bf_diff;
				my = wn_eff;
			end
			ST_BF_WR0: begin
				scr_we    = 1'b1;
				scr_waddr = {bank, a0};
				scr_wdata = bf_x0;
			end
			ST_BF_WR1: begin
				scr_we    = 1'b1;
				scr_waddr = {bank, a1};
				scr_wdata = bf_x1;
			end
			ST_EL_RD: begin
				scr_re     = 1'b1;
				scr_raddr0 = {1'b0, j_q};
				scr_raddr1 = {1'b1, j_q};
			end
			ST_EL_MUL: begin
				mx = sr0_q;
				my = (phase_q == PH_SCALE) ? scl_k[ln_q] : sr1_q;
			end
			ST_EL_WR: begin
				if (phase_q == PH_SCALE) begin
					wa_we    = 1'b1;
					wa_waddr = j_q;
					wa_wdata = mz;
				end else begin
					scr_we    = 1'b1;
					scr_waddr = {1'b0, j_q};
					scr_wdata = mz;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wa_we) wa_mem[wa_waddr] <= wa_wdata;
		if (wa_re) wa_rd_q <= wa_mem[wa_raddr];
	end

	always_ff @(posedge clk) begin
		if (wb_we) wb_mem[wb_waddr] <= wb_wdata;
		if (wb_re) wb_rd_q <= wb_mem[j_q];
	end

	always_ff @(posedge clk) begin
		if (scr_we) scr_mem[scr_waddr] <= scr_wdata;
		if (scr_re) begin
			sr0_q <= scr_mem[scr_raddr0];
			sr1_q <= scr_mem[scr_raddr1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			length_a_q <= '0;
			length_b_q <= '0;
		end else if (cfg_we) begin
			if (cfg_addr == 1'b0) length_a_q <= cfg_wdata;
			else length_b_q <= cfg_wdata;
		end
	end

	// loop counters and phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_FWD_A;
			c_q     <= '0;
			ln_q    <= '0;
			lg_q    <= '0;
			j_q     <= '0;
			end_q   <= '0;
			wait_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (acc && mode_in == MODE_CONV && !too_long) begin
						c_q     <= c_comb;
						ln_q    <= ln_comb;
						lg_q    <= ln_comb;
						j_q     <= '0;
						end_q   <= nm1_new;
						phase_q <= PH_FWD_A;
					end
				end
				ST_LOAD_WB: begin
					if (!j_end) begin
						j_q <= j_q + AW'(1);
					end else begin
						j_q <= '0;
						if (ln_q == '0) begin
							phase_q <= PH_POINT;
							end_q   <= '0;
						end else begin
							phase_q <= PH_FWD_A;
							end_q   <= nm1_ln >> 1;
						end
					end
				end
				ST_BF_MUL, ST_EL_MUL: wait_q <= '0;
				ST_BF_WAIT, ST_EL_WAIT: wait_q <= wait_q + WTW'(1);
				ST_BF_WR1: begin
					if (!j_end) begin
						j_q <= j_q + AW'(1);
					end else begin
						j_q <= '0;
						if (!last_stage) begin
							lg_q <= inv_pass ? lg_q + HW'(1) : lg_q - HW'(1);
						end else begin
							unique case (phase_q)
								PH_FWD_A: begin
									phase_q <= PH_FWD_B;
									lg_q    <= ln_q;
								end
								PH_FWD_B: begin
									phase_q <= PH_POINT;
									end_q   <= nm1_ln;
								end
								default: begin
									phase_q <= PH_SCALE;
									end_q   <= AW'(c_q - CW'(1));
								end
							endcase
						end
					end
				end
				ST_EL_WR: begin
					if (!j_end) begin
						j_q <= j_q + AW'(1);
					end else begin
						j_q <= '0;
						if (phase_q == PH_POINT) begin
							if (ln_q == '0) begin
								phase_q <= PH_SCALE;
								end_q   <= AW'(c_q - CW'(1));
							end else begin
								phase_q <= PH_INV;
								lg_q    <= HW'(1);
								end_q   <= nm1_ln >> 1;
							end
						end
					end
				end
				default: ;
			endcase
		end
	end

	// butterfly operands and running twiddle
	always_ff @(posedge clk) begin
		if (state_q == ST_BF_MUL) begin
			u_q <= sr0_q;
			v_q <= sr1_q;
		end
		if (state_q == ST_BF_WR0) begin
			p_q  <= mz;
			wn_q <= wz;
		end
	end

	// results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q   <= 1'b0;
			rsel_q   <= 1'b0;
			status_q <= STS_OK;
			plen_q   <= '0;
		end else begin
			done_q <= 1'b0;
			rsel_q <= 1'b0;
			if (acc) begin
				unique case (mode_in)
					MODE_WR_A, MODE_WR_B: begin
						done_q   <= 1'b1;
						status_q <= idx_ok ? STS_OK : STS_RANGE;
					end
					MODE_READ: begin
						done_q   <= 1'b1;
						rsel_q   <= rd_ok;
						status_q <= rd_ok ? STS_OK : STS_RANGE;
					end
					MODE_CONV: begin
						if (too_long) begin
							done_q   <= 1'b1;
							status_q <= STS_TOO_LONG;
							plen_q   <= '0;
						end
					end
					default: ;
				endcase
			end
			if (state_q == ST_FINISH) begin
				done_q   <= 1'b1;
				status_q <= STS_OK;
				plen_q   <= LEN_W'(c_q);
			end
		end
	end

	assign done          = done_q;
	assign status        = status_q;
	assign product_value = rsel_q ? wa_rd_q : '0;

`ifndef NO_ASSERTIONS
	a_b_held : assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !wb_we)
		else $error("work_b written during a convolution");

	a_val_ok : assert property (@(posedge clk) disable iff (!arst_n)
		done && status != STS_OK |-> product_value == '0)
		else $error("nonzero value on a failed result");

	a_finish : assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FINISH |=> done && status == STS_OK && !busy)
		else $error("convolution end without a result");

	a_bf_span : assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_BF_WR1 |-> lg_q != '0 && $past(state_q) == ST_BF_WR0)
		else $error("butterfly write out of sequence");
`endif

endmodule

[verif/tb_ntt_convolution_top.sv]
// Self-checking testbench for ntt_convolution_top: directed table, then random episodes.
module tb_ntt_convolution_top;
	import ntt_pkg::*;

	localparam int DEPTH = 1 << LOG_SIZE_DEF;
	localparam int ITEM_GOAL = 1050;
	// bound on cycles with no transfer; a full-size convolve holds busy well within it
	localparam int WATCH_LIMIT = 1_000_000;
	localparam logic REG_LEN_A = 1'b0;
	localparam logic REG_LEN_B = 1'b1;
	localparam logic [29:0] VAL_MAX = 30'h3FFF_FFFF;

	typedef struct packed {
		logic [VAL_W-1:0] value;
		sts_t             sts;
	} coef_result_t;

	// one row of the directed table: either a register write or an item
	typedef struct {
		bit               is_reg;
		mode_t            op;
		logic [IDX_W-1:0] idx;
		logic [VAL_W-1:0] val;
		bit               known;
		logic [VAL_W-1:0] want_value;
		sts_t             want_sts;
	} script_row_t;

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	logic [MODE_W-1:0] mode;
	logic [IDX_W-1:0]  index;
	logic [VAL_W-1:0]  coefficient_value;
	logic              done;
	logic [VAL_W-1:0]  product_value;
	logic [STS_W-1:0]  status;
	logic              cfg_we;
	logic              cfg_addr;
	logic [LEN_W-1:0]  cfg_wdata;

	// shadow state of the block
	logic [VAL_W-1:0] coef_a [DEPTH];
	logic [VAL_W-1:0] coef_b [DEPTH];
	bit               a_set [DEPTH];
	bit               b_set [DEPTH];
	int               len_a;
	int               len_b;
	int               prod_len;

	coef_result_t pending_results[$];
	bit           burst;
	int           items_sent;
	int           errors;
	int           results_checked;
	int           conv_ok;
	int           conv_long;
	int           reads_ok;
	int           idle_cycles;

	ntt_convolution_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.mode(mode),
		.index(index),
		.coefficient_value(coefficient_value),
		.done(done),
		.product_value(product_value),
		.status(status),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Linear convolution of the shadow sequences, written back over coef_a.
	function automatic sts_t convolve_shadow();
		longint unsigned acc [DEPTH];
		longint unsigned ra;
		longint unsigned rb;
		longint unsigned p;
		int c;
		int n;
		int ea;
		int eb;
		p = 64'(PRIME);
		c = (len_a + len_b > 0) ? len_a + len_b - 1 : 0;
		if (c > DEPTH) begin
			prod_len = 0;
			return STS_TOO_LONG;
		end
		n = 1;
		while (n < c)
			n = n << 1;
		ea = (len_a < n) ? len_a : n;
		eb = (len_b < n) ? len_b : n;
		for (int i = 0; i < DEPTH; i++)
			acc[i] = 0;
		for (int i = 0; i < ea; i++) begin
			ra = 64'(coef_a[i]) % p;
			if (ra != 0) begin
				for (int j = 0; j < eb; j++) begin
					rb = 64'(coef_b[j]) % p;
					acc[i + j] = (acc[i + j] + (ra * rb) % p) % p;
				end
			end
		end
		for (int i = 0; i < c; i++) begin
			coef_a[i] = VAL_W'(acc[i]);
			a_set[i] = 1'b1;
		end
		prod_len = c;
		return STS_OK;
	endfunction

	// Advance the shadow state by one item and give the result it causes.
	function automatic coef_result_t predict_coef(mode_t op, logic [IDX_W-1:0] idx,
			logic [VAL_W-1:0] val);
		coef_result_t r;
		r.value = '0;
		r.sts = STS_OK;
		case (op)
			MODE_WR_A: begin
				coef_a[idx] = val;
				a_set[idx] = 1'b1;
			end
			MODE_WR_B: begin
				coef_b[idx] = val;
				b_set[idx] = 1'b1;
			end
			MODE_CONV: begin
				r.sts = convolve_shadow();
			end
			default: begin
				if (int'(idx) < prod_len)
					r.value = coef_a[idx];
				else
					r.sts = STS_RANGE;
			end
		endcase
		return r;
	endfunction

	// Transfer one item; hold start high across back-to-back items.
	task automatic send_item(mode_t op, logic [IDX_W-1:0] idx, logic [VAL_W-1:0] val,
			bit known, coef_result_t want);
		coef_result_t got;
		int gap;
		gap = burst ? 0 : $urandom_range(0, 19);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		mode <= op;
		index <= idx;
		coefficient_value <= val;
		do
			@(posedge clk);
		while (busy);
		got = predict_coef(op, idx, val);
		if (op == MODE_CONV) begin
			if (got.sts == STS_OK)
				conv_ok++;
			else
				conv_long++;
		end
		if (op == MODE_READ && got.sts == STS_OK)
			reads_ok++;
		pending_results.insert(pending_results.size(), known ? want : got);
		items_sent++;
	endtask

	task automatic send(mode_t op, logic [IDX_W-1:0] idx, logic [VAL_W-1:0] val);
		send_item(op, idx, val, 1'b0, '{value: '0, sts: STS_OK});
	endtask

	// Write a length register once the block has drained.
	task automatic set_length(logic which, int len);
		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= which;
		cfg_wdata <= LEN_W'(len);
		@(posedge clk);
		cfg_we <= 1'b0;
		if (which == REG_LEN_A)
			len_a = len & 11'h7FF;
		else
			len_b = len & 11'h7FF;
	endtask

	function automatic logic [VAL_W-1:0] pick_value();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return PRIME - 30'd1;
			2: return VAL_MAX;
			3: return VAL_W'($urandom_range(32'(PRIME), 32'(VAL_MAX)));
			default: return VAL_W'($urandom);
		endcase
	endfunction

	// Read back product coefficients: all of a short product, a sample of a long one.
	task automatic read_product();
		int c;
		c = prod_len;
		if (c <= 40) begin
			for (int i = 0; i < c; i++)
				send(MODE_READ, IDX_W'(i), pick_value());
		end else begin
			for (int i = 0; i < 30; i++)
				send(MODE_READ, IDX_W'($urandom_range(0, c - 1)), pick_value());
		end
		if (c < DEPTH)
			send(MODE_READ, IDX_W'(c), '0);
		if ($urandom_range(0, 1) == 0)
			send(MODE_READ, IDX_W'(DEPTH - 1), pick_value());
	endtask

	// Fill every entry that a convolve at the current lengths will read.
	task automatic fill_needed(int extra);
		int todo_mode[$];
		int todo_idx[$];
		int k;
		int ea;
		int eb;
		ea = (len_a < DEPTH) ? len_a : DEPTH;
		eb = (len_b < DEPTH) ? len_b : DEPTH;
		for (int i = 0; i < ea; i++)
			if (!a_set[i]) begin
				todo_mode.insert(todo_mode.size(), MODE_WR_A);
				todo_idx.insert(todo_idx.size(), i);
			end
		for (int i = 0; i < eb; i++)
			if (!b_set[i]) begin
				todo_mode.insert(todo_mode.size(), MODE_WR_B);
				todo_idx.insert(todo_idx.size(), i);
			end
		// rewrites and stray writes anywhere in the store
		for (int i = 0; i < extra; i++) begin
			todo_mode.insert(todo_mode.size(), $urandom_range(0, 1));
			todo_idx.insert(todo_idx.size(),
				($urandom_range(0, 3) == 0) ? $urandom_range(0, DEPTH - 1) :
				$urandom_range(0, ((ea > eb ? ea : eb) + 3 < DEPTH) ?
				(ea > eb ? ea : eb) + 3 : DEPTH - 1));
		end
		while (todo_idx.size() != 0) begin
			k = $urandom_range(0, todo_idx.size() - 1);
			if ($urandom_range(0, 7) == 0)
				send(MODE_READ, IDX_W'($urandom), pick_value());
			send(mode_t'(todo_mode[k]), IDX_W'(todo_idx[k]), pick_value());
			todo_mode.delete(k);
			todo_idx.delete(k);
		end
	endtask

	// One random episode: lengths, coefficient writes, convolve, read back.
	task automatic run_episode();
		int la;
		int lb;
		int kind;
		burst = ($urandom_range(0, 3) == 0);
		kind = $urandom_range(0, 9);
		if (kind == 0) begin
			// product too long: nothing is read, so no writes are needed
			la = $urandom_range(1025, 2047);
			lb = $urandom_range(2, 2047);
			if ($urandom_range(0, 1) == 0) begin
				kind = la;
				la = lb;
				lb = kind;
			end
		end else if (kind == 1) begin
			la = $urandom_range(0, 120);
			lb = $urandom_range(0, 120);
		end else begin
			la = $urandom_range(0, 24);
			lb = $urandom_range(0, 24);
		end
		set_length(REG_LEN_A, la);
		set_length(REG_LEN_B, lb);
		if (la + lb - 1 <= DEPTH)
			fill_needed($urandom_range(0, 4));
		send(MODE_CONV, IDX_W'($urandom), VAL_W'($urandom));
		// convolve again without rewrites: the product becomes sequence a
		if ($urandom_range(0, 3) == 0)
			send(MODE_CONV, IDX_W'($urandom), VAL_W'($urandom));
		read_product();
	endtask

	// Grow coef_a to the full store by chained convolves, then hit the length extremes.
	task automatic run_full_store();
		burst = 1'b0;
		set_length(REG_LEN_A, 256);
		set_length(REG_LEN_B, 256);
		fill_needed(0);
		send(MODE_CONV, '0, '0);
		set_length(REG_LEN_A, 511);
		send(MODE_CONV, '0, '0);
		set_length(REG_LEN_A, 766);
		send(MODE_CONV, '0, '0);
		// 769 + 256 - 1 fills the last entries exactly
		set_length(REG_LEN_A, 769);
		send(MODE_CONV, '0, '0);
		read_product();
		set_length(REG_LEN_A, 1024);
		set_length(REG_LEN_B, 1);
		send(MODE_CONV, '0, '0);
		send(MODE_READ, IDX_W'(DEPTH - 1), '0);
		send(MODE_READ, '0, '0);
		// a length past the store passes only against an empty other sequence
		set_length(REG_LEN_A, 1025);
		set_length(REG_LEN_B, 0);
		send(MODE_CONV, '0, '0);
		send(MODE_READ, IDX_W'(DEPTH - 1), '0);
		set_length(REG_LEN_A, 1024);
		set_length(REG_LEN_B, 2);
		send(MODE_CONV, '0, '0);
		send(MODE_READ, '0, '0);
	endtask

	script_row_t script [] = '{
		// nothing convolved yet: every read fails
		'{0, MODE_READ, 10'd0, 30'd0, 1, 30'd0, STS_RANGE},
		'{0, MODE_READ, 10'd1023, VAL_MAX, 1, 30'd0, STS_RANGE},
		// both lengths zero: empty product
		'{0, MODE_CONV, 10'd1023, VAL_MAX, 1, 30'd0, STS_OK},
		'{0, MODE_READ, 10'd0, 30'd0, 1, 30'd0, STS_RANGE},
		'{0, MODE_WR_A, 10'd0, VAL_MAX, 1, 30'd0, STS_OK},
		'{0, MODE_WR_A, 10'd1, 30'd998244352, 1, 30'd0, STS_OK},
		'{0, MODE_WR_A, 10'd1023, 30'd0, 1, 30'd0, STS_OK},
		'{0, MODE_WR_B, 10'd0, 30'd998244352, 1, 30'd0, STS_OK},
		'{0, MODE_WR_B, 10'd1, 30'd1, 1, 30'd0, STS_OK},
		'{0, MODE_WR_B, 10'd1023, VAL_MAX, 1, 30'd0, STS_OK},
		'{1, MODE_WR_A, 10'(REG_LEN_A), 30'd2, 0, 30'd0, STS_OK},
		'{1, MODE_WR_A, 10'(REG_LEN_B), 30'd2, 0, 30'd0, STS_OK},
		'{0, MODE_CONV, 10'd0, 30'd0, 1, 30'd0, STS_OK},
		'{0, MODE_READ, 10'd0, 30'd0, 0, 30'd0, STS_OK},
		'{0, MODE_READ, 10'd1, 30'd0, 0, 30'd0, STS_OK},
		'{0, MODE_READ, 10'd2, 30'd0, 0, 30'd0, STS_OK},
		'{0, MODE_READ, 10'd3, 30'd0, 1, 30'd0, STS_RANGE},
		// largest register values: product too long, old product dropped
		'{1, MODE_WR_A, 10'(REG_LEN_A), 30'd2047, 0, 30'd0, STS_OK},
		'{1, MODE_WR_A, 10'(REG_LEN_B), 30'd2047, 0, 30'd0, STS_OK},
		'{0, MODE_CONV, 10'd0, 30'd0, 1, 30'd0, STS_TOO_LONG},
		'{0, MODE_READ, 10'd0, 30'd0, 1, 30'd0, STS_RANGE},
		// one coefficient against none: zero-length product
		'{1, MODE_WR_A, 10'(REG_LEN_A), 30'd1, 0, 30'd0, STS_OK},
		'{1, MODE_WR_A, 10'(REG_LEN_B), 30'd0, 0, 30'd0, STS_OK},
		'{0, MODE_CONV, 10'd0, 30'd0, 1, 30'd0, STS_OK},
		'{0, MODE_READ, 10'd0, 30'd0, 1, 30'd0, STS_RANGE},
		'{1, MODE_WR_A, 10'(REG_LEN_B), 30'd1, 0, 30'd0, STS_OK},
		'{0, MODE_CONV, 10'd0, 30'd0, 1, 30'd0, STS_OK},
		'{0, MODE_READ, 10'd0, 30'd0, 0, 30'd0, STS_OK}
	};

	initial begin
		bit chained;
		arst_n = 1'b0;
		start = 1'b0;
		mode = MODE_WR_A;
		index = '0;
		coefficient_value = '0;
		cfg_we = 1'b0;
		cfg_addr = REG_LEN_A;
		cfg_wdata = '0;
		burst = 1'b0;
		chained = 1'b0;
		items_sent = 0;
		errors = 0;
		results_checked = 0;
		conv_ok = 0;
		conv_long = 0;
		reads_ok = 0;
		len_a = 0;
		len_b = 0;
		prod_len = 0;
		for (int i = 0; i < DEPTH; i++) begin
			coef_a[i] = '0;
			coef_b[i] = '0;
			a_set[i] = 1'b0;
			b_set[i] = 1'b0;
		end
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table; known rows carry their own expectation
		foreach (script[i]) begin
			if (script[i].is_reg)
				set_length(script[i].idx[0], int'(script[i].val));
			else
				send_item(script[i].op, script[i].idx, script[i].val, script[i].known,
					'{value: script[i].want_value, sts: script[i].want_sts});
		end

		// random episodes, with the full-store pass dropped in partway
		while (items_sent < ITEM_GOAL) begin
			if (!chained && items_sent > 300) begin
				run_full_store();
				chained = 1'b1;
			end else begin
				run_episode();
			end
		end

		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		$display("Covered %0d items: %0d convolves done, %0d too long, %0d reads returned data.",
			items_sent, conv_ok, conv_long, reads_ok);
		$display("Checked %0d results, %0d mismatches.", results_checked, errors);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// Check each result against the oldest expectation; watch for a hang.
	always @(posedge clk) begin
		coef_result_t want;
		if (arst_n) begin
			if (done) begin
				results_checked++;
				if (pending_results.size() == 0) begin
					errors++;
					$display("%0t: result with nothing expected: value %0d status %0d",
						$time, product_value, status);
				end else begin
					want = pending_results.pop_front();
					if (product_value !== want.value) begin
						errors++;
						$display("%0t: product_value expected %0d actual %0d",
							$time, want.value, product_value);
					end
					if (status !== want.sts) begin
						errors++;
						$display("%0t: status expected %0d actual %0d",
							$time, want.sts, status);
					end
				end
			end
			if ((start && !busy) || done || cfg_we)
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCH_LIMIT) begin
				$display("Timeout: no transfer for %0d cycles.", WATCH_LIMIT);
				$display("FAIL");
				$finish;
			end
		end else begin
			idle_cycles <= 0;
		end
	end

endmodule
